### hdl/sss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sinusoid sum synthesizer package
// Shared constants, controller/datapath interface types and the quarter-wave
// sine entry function used to build the lookup table at elaboration.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int IDX_W    = 6;
    localparam int FREQ_W   = 32;
    localparam int AMP_W    = 16;
    localparam int OFFS_W   = 32;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int ELEV_W   = 22;
    localparam int SINE_W   = 15;
    localparam int ELEV_MAX = 2097151;
    localparam int ELEV_MIN = -2097152;
    localparam int ENTRY_W  = FREQ_W + AMP_W + OFFS_W;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic ram_write;
        logic start;
        logic issue;
        logic load_result;
    } sss_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic item_sample;
        logic count_zero;
        logic issue_last;
        logic pipe_empty;
    } sss_status_t;

    // Quarter-wave sine entry k of a 2^table_bits table, Q30 Taylor series
    // scaled to 32767 with rounding.
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned table_bits,
                                                     input int unsigned k);
        logic        [63:0] x;
        logic        [63:0] term;
        logic signed [63:0] sum;
        logic        [63:0] v;
        int unsigned        n;
        x    = (64'd1686629713 * 64'(k)) >> table_bits;
        term = x;
        sum  = $signed(x);
        for (n = 1; n <= 8; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

### hdl/sss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/sss_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sinusoid sum synthesizer controller
// Sequences table writes and per-sample component sweeps, and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module sss_ctrl
    import sss_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output sss_cmd_t    cmd,
    input  sss_status_t status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_RUN    = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.item_sample) begin
                    cmd.start  = 1'b1;
                    state_next = ST_RUN;
                end else begin
                    cmd.ram_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (status.count_zero) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.issue = 1'b1;
                    if (status.issue_last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until the transaction completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### hdl/sss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sinusoid sum synthesizer datapath
// Item register, component table, phase multiply, sine lookup, amplitude
// multiply, accumulator and saturated result, one component per cycle.
// ----------------------------------------------------------------------------
module sss_datapath
    import sss_pkg::*;
#(
    parameter int COMPONENTS      = 64,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_opcode,
    input  logic [IDX_W-1:0]         s_component_index,
    input  logic [FREQ_W-1:0]        s_frequency_word,
    input  logic [AMP_W-1:0]         s_amplitude,
    input  logic [OFFS_W-1:0]        s_phase_offset,
    input  logic [TIME_W-1:0]        s_sample_time,
    input  logic                     cfg_wr_en,
    input  logic [COUNT_W-1:0]       cfg_wr_data,
    input  sss_cmd_t                 cmd,
    output sss_status_t              status,
    output logic signed [ELEV_W-1:0] m_elevation
);

    localparam int ADDR_W = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
    localparam int CNT_W  = $clog2(COMPONENTS + 1);
    localparam int QSIZE  = 1 << SINE_TABLE_BITS;
    localparam int QIDX_W = SINE_TABLE_BITS + 1;
    localparam int ACC_W  = 17 + $clog2(COMPONENTS + 1);

    // Quarter-wave sine table, fixed at elaboration
    logic [SINE_W-1:0] sine_rom [QSIZE + 1];
    for (genvar g = 0; g <= QSIZE; g++) begin : g_sine
        assign sine_rom[g] = sine_entry(SINE_TABLE_BITS, g);
    end

    // Configuration and item registers
    logic [COUNT_W-1:0] cfg_count_reg;
    logic               opcode_reg;
    logic [IDX_W-1:0]   index_reg;
    logic [FREQ_W-1:0]  freq_in_reg;
    logic [AMP_W-1:0]   amp_in_reg;
    logic [OFFS_W-1:0]  offs_in_reg;
    logic [TIME_W-1:0]  time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg <= '0;
        end else if (cfg_wr_en) begin
            cfg_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            opcode_reg  <= s_opcode;
            index_reg   <= s_component_index;
            freq_in_reg <= s_frequency_word;
            amp_in_reg  <= s_amplitude;
            offs_in_reg <= s_phase_offset;
            time_reg    <= s_sample_time;
        end
    end

    // Component table; drop writes beyond its depth
    logic                wr_in_range;
    logic [ENTRY_W-1:0]  entry_rd;
    logic [CNT_W-1:0]    iss_cnt_reg;
    logic [CNT_W-1:0]    count_reg;

    assign wr_in_range = (32'(index_reg) < COMPONENTS);

    sss_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(COMPONENTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (cmd.ram_write && wr_in_range),
        .wr_addr (ADDR_W'(index_reg)),
        .wr_data ({freq_in_reg, amp_in_reg, offs_in_reg}),
        .rd_en   (cmd.issue),
        .rd_addr (iss_cnt_reg[ADDR_W-1:0]),
        .rd_data (entry_rd)
    );

    // Issue counter and clamped component count
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            iss_cnt_reg <= '0;
            if (32'(cfg_count_reg) > COMPONENTS) begin
                count_reg <= CNT_W'(COMPONENTS);
            end else begin
                count_reg <= CNT_W'(cfg_count_reg);
            end
        end else if (cmd.issue) begin
            iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
        end
    end

    // Pipeline valids
    logic rd_v_reg;
    logic mul_v_reg;
    logic sin_v_reg;
    logic prd_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
            sin_v_reg <= 1'b0;
            prd_v_reg <= 1'b0;
        end else begin
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
            sin_v_reg <= mul_v_reg;
            prd_v_reg <= sin_v_reg;
        end
    end

    // Phase product, low 32 bits of frequency times time
    logic [FREQ_W-1:0] ent_freq;
    logic [AMP_W-1:0]  ent_amp;
    logic [OFFS_W-1:0] ent_offs;
    logic [31:0]       prod_reg;
    logic [OFFS_W-1:0] offs_reg;
    logic [AMP_W-1:0]  amp1_reg;

    assign {ent_freq, ent_amp, ent_offs} = entry_rd;

    always_ff @(posedge aclk) begin
        if (rd_v_reg) begin
            prod_reg <= 32'(ent_freq * time_reg);
            offs_reg <= ent_offs;
            amp1_reg <= ent_amp;
        end
    end

    // Phase to quadrant and table index, registered lookup
    logic [31:0]                phase;
    logic [SINE_TABLE_BITS-1:0] k_raw;
    logic [QIDX_W-1:0]          k_idx;
    logic [SINE_W-1:0]          sine_reg;
    logic                       neg_reg;
    logic [AMP_W-1:0]           amp2_reg;

    assign phase = prod_reg + offs_reg;
    assign k_raw = phase[29 -: SINE_TABLE_BITS];
    assign k_idx = phase[30] ? (QIDX_W'(QSIZE) - {1'b0, k_raw}) : {1'b0, k_raw};

    always_ff @(posedge aclk) begin
        if (mul_v_reg) begin
            sine_reg <= sine_rom[k_idx];
            neg_reg  <= phase[31];
            amp2_reg <= amp1_reg;
        end
    end

    // Amplitude times signed sine
    logic signed [SINE_W:0]   sine_s;
    logic signed [32:0]       prd_reg;

    assign sine_s = neg_reg ? -$signed({1'b0, sine_reg}) : $signed({1'b0, sine_reg});

    always_ff @(posedge aclk) begin
        if (sin_v_reg) begin
            prd_reg <= $signed({1'b0, amp2_reg}) * sine_s;
        end
    end

    // Accumulate floor of product over 2^16
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [32:0]      term;

    assign term = prd_reg >>> 16;

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            acc_reg <= '0;
        end else if (prd_v_reg) begin
            acc_reg <= acc_reg + ACC_W'(term);
        end
    end

    // Saturate into the result register
    int                       acc_wide;
    logic signed [ELEV_W-1:0] elev_next;
    logic signed [ELEV_W-1:0] elev_reg;

    assign acc_wide = int'(acc_reg);

    always_comb begin
        if (acc_wide > ELEV_MAX) begin
            elev_next = ELEV_W'(ELEV_MAX);
        end else if (acc_wide < ELEV_MIN) begin
            elev_next = ELEV_W'(ELEV_MIN);
        end else begin
            elev_next = ELEV_W'(acc_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            elev_reg <= elev_next;
        end
    end

    assign m_elevation = elev_reg;

    // Status to the controller
    assign status.item_sample = opcode_reg;
    assign status.count_zero  = (count_reg == '0);
    assign status.issue_last  = ((iss_cnt_reg + CNT_W'(1)) == count_reg);
    assign status.pipe_empty  = !(rd_v_reg || mul_v_reg || sin_v_reg || prd_v_reg);

endmodule

### hdl/sinusoid_sum_synthesizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sinusoid sum synthesizer
// Write transactions load one wave component (frequency, amplitude, phase
// offset); sample transactions return the summed elevation at a given time.
// A write transaction passes through a decode state back to idle. For a
// sample transaction the single read port of the component table feeds one
// component per cycle into a four-stage chain of phase multiply, sine
// lookup, amplitude multiply and accumulate, which then drains before the
// saturated sum is registered; with no active components nothing is issued.
// The next transaction is accepted while a result waits on the output; a
// finished sum is held until the waiting result is taken. The active count
// is clamped to COMPONENTS; entries that were never written give undefined
// terms.
// ----------------------------------------------------------------------------
module sinusoid_sum_synthesizer_unit
    import sss_pkg::*;
#(
    parameter int COMPONENTS      = 64,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [IDX_W-1:0]         s_component_index,
    input  logic [FREQ_W-1:0]        s_frequency_word,
    input  logic [AMP_W-1:0]         s_amplitude,
    input  logic [OFFS_W-1:0]        s_phase_offset,
    input  logic [TIME_W-1:0]        s_sample_time,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ELEV_W-1:0] m_elevation,
    input  logic                     cfg_wr_en,
    input  logic [COUNT_W-1:0]       cfg_wr_data
);

    sss_cmd_t    cmd;
    sss_status_t status;

    // Sequencer
    sss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    // Table, arithmetic chain and result register
    sss_datapath #(
        .COMPONENTS      (COMPONENTS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_opcode          (s_opcode),
        .s_component_index (s_component_index),
        .s_frequency_word  (s_frequency_word),
        .s_amplitude       (s_amplitude),
        .s_phase_offset    (s_phase_offset),
        .s_sample_time     (s_sample_time),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .cmd               (cmd),
        .status            (status),
        .m_elevation       (m_elevation)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sinusoid sum synthesizer testbench
// Loads wave components and requests elevation samples through the input
// channel, reprograms the active component count between phases while the
// block is idle, and checks every returned elevation against an in-bench
// prediction built from its own quarter-wave sine table and component tables.
// Both channels idle at random; the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
    import sss_pkg::*;

    localparam int COMPONENTS   = 64;
    localparam int SINE_BITS    = 10;
    localparam int QSIZE        = 1 << SINE_BITS;
    localparam int ITEM_TARGET  = 1350;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_PENDING = 8;
    localparam int HOLD_CYCLES  = 600;
    localparam int LIMIT_CYCLES = 1_200_000;

    typedef enum logic {
        OP_LOAD_COMPONENT = 1'b0,
        OP_SAMPLE         = 1'b1
    } wave_op_t;

    typedef struct {
        wave_op_t          op;
        logic [IDX_W-1:0]  idx;
        logic [FREQ_W-1:0] freq;
        logic [AMP_W-1:0]  amp;
        logic [OFFS_W-1:0] offs;
        logic [TIME_W-1:0] t;
    } wave_txn_t;

    logic                     aclk              = 1'b0;
    logic                     aresetn           = 1'b0;
    logic                     s_valid           = 1'b0;
    logic                     s_ready;
    logic                     s_opcode          = 1'b0;
    logic [IDX_W-1:0]         s_component_index = '0;
    logic [FREQ_W-1:0]        s_frequency_word  = '0;
    logic [AMP_W-1:0]         s_amplitude       = '0;
    logic [OFFS_W-1:0]        s_phase_offset    = '0;
    logic [TIME_W-1:0]        s_sample_time     = '0;
    logic                     m_valid;
    logic                     m_ready           = 1'b0;
    logic signed [ELEV_W-1:0] m_elevation;
    logic                     cfg_wr_en         = 1'b0;
    logic [COUNT_W-1:0]       cfg_wr_data       = '0;

    // Predictor state: sine table, component tables and active count
    int                       sine_quarter [0:QSIZE];
    logic [FREQ_W-1:0]        freq_tab [COMPONENTS];
    logic [AMP_W-1:0]         amp_tab  [COMPONENTS];
    logic [OFFS_W-1:0]        offs_tab [COMPONENTS];
    logic [COUNT_W-1:0]       active_count = '0;

    wave_txn_t                stim_q [$];
    logic signed [ELEV_W-1:0] elev_q [$];
    wave_txn_t                bus_txn;
    logic signed [ELEV_W-1:0] want_elev;

    int   n_issued   = 0;
    int   n_accepted = 0;
    int   n_errors   = 0;
    int   idle_mode  = 0;
    int   gap_left   = 0;
    int   stall_left = 0;
    int   hold_left  = 0;
    logic hold_done  = 1'b0;

    sinusoid_sum_synthesizer_unit #(
        .COMPONENTS      (COMPONENTS),
        .SINE_TABLE_BITS (SINE_BITS)
    ) u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_component_index (s_component_index),
        .s_frequency_word  (s_frequency_word),
        .s_amplitude       (s_amplitude),
        .s_phase_offset    (s_phase_offset),
        .s_sample_time     (s_sample_time),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_elevation       (m_elevation),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Quarter-wave sine entry: Q30 Taylor series of sin(pi/2 * k / QSIZE),
    // scaled to Q15 with rounding
    function automatic int taylor_sine_q15(input int unsigned k);
        longint unsigned x;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        x    = (64'd1686629713 * 64'(k)) >> SINE_BITS;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        return (v > 64'd32767) ? 32767 : int'(v);
    endfunction

    // Signed Q1.15 sine of a Q0.32 turn: quadrant from the top bits,
    // mirror in odd quadrants, negate in the second half of the turn
    function automatic int wave_sine(input logic [31:0] turn);
        logic [1:0]  quad;
        int unsigned k;
        quad = turn[31:30];
        k    = 32'(turn[29 -: SINE_BITS]);
        if (quad[0]) begin
            k = QSIZE - k;
        end
        return quad[1] ? -sine_quarter[k] : sine_quarter[k];
    endfunction

    // Saturated sum of floor(amp * sine / 2^16) over the active components
    function automatic logic signed [ELEV_W-1:0] predict_elevation(
        input logic [TIME_W-1:0] t);
        longint      acc;
        int          n_act;
        logic [31:0] turn;
        acc   = 0;
        n_act = (active_count > COMPONENTS) ? COMPONENTS : int'(active_count);
        for (int j = 0; j < n_act; j++) begin
            turn = freq_tab[j] * t + offs_tab[j];
            acc  = acc + ((longint'(amp_tab[j]) * wave_sine(turn)) >>> 16);
        end
        if (acc > ELEV_MAX) begin
            acc = ELEV_MAX;
        end
        if (acc < ELEV_MIN) begin
            acc = ELEV_MIN;
        end
        return acc[ELEV_W-1:0];
    endfunction

    // Idle length: none in calm phases, else mostly short with a few long
    function automatic int pick_gap(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 50) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Field value biased towards zero, all-ones and other corner patterns
    function automatic logic [31:0] biased_word(input int bits);
        logic [31:0] mask;
        logic [31:0] v;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2:       v = $urandom_range(0, 15);
            3:       v = $urandom << $urandom_range(16, 31);
            4:       v = 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: v = $urandom;
        endcase
        return v & mask;
    endfunction

    function automatic wave_txn_t random_txn();
        wave_txn_t w;
        w.op   = ($urandom_range(0, 99) < 40) ? OP_LOAD_COMPONENT : OP_SAMPLE;
        w.idx  = IDX_W'($urandom_range(0, COMPONENTS - 1));
        w.freq = biased_word(FREQ_W);
        w.amp  = AMP_W'(biased_word(AMP_W));
        w.offs = biased_word(OFFS_W);
        w.t    = biased_word(TIME_W);
        return w;
    endfunction

    task automatic enqueue_txn(input wave_txn_t w);
        stim_q.push_back(w);
        n_issued++;
    endtask

    // Component load; the unused time field carries random filler
    task automatic queue_load(input int idx, input logic [31:0] freq,
                              input logic [15:0] amp, input logic [31:0] offs);
        wave_txn_t w;
        w      = random_txn();
        w.op   = OP_LOAD_COMPONENT;
        w.idx  = IDX_W'(idx);
        w.freq = freq;
        w.amp  = amp;
        w.offs = offs;
        enqueue_txn(w);
    endtask

    // Sample request; the unused component fields carry random filler
    task automatic queue_sample(input logic [31:0] t);
        wave_txn_t w;
        w    = random_txn();
        w.op = OP_SAMPLE;
        w.t  = t;
        enqueue_txn(w);
    endtask

    // Wait until every transaction is taken and every result has returned,
    // then let a write still in flight settle
    task automatic wait_idle();
        while (n_accepted != n_issued || elev_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_count(input int value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= COUNT_W'(value);
        active_count  = COUNT_W'(value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // Input driver: update the prediction on each accepted transaction,
    // then present the next pending one after its gap
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left  = 0;
        end else begin
            if (s_valid && s_ready) begin
                n_accepted++;
                if (bus_txn.op == OP_LOAD_COMPONENT) begin
                    freq_tab[bus_txn.idx] = bus_txn.freq;
                    amp_tab[bus_txn.idx]  = bus_txn.amp;
                    offs_tab[bus_txn.idx] = bus_txn.offs;
                end else begin
                    elev_q.push_back(predict_elevation(bus_txn.t));
                end
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    bus_txn            = stim_q.pop_front();
                    s_valid           <= 1'b1;
                    s_opcode          <= bus_txn.op;
                    s_component_index <= bus_txn.idx;
                    s_frequency_word  <= bus_txn.freq;
                    s_amplitude       <= bus_txn.amp;
                    s_phase_offset    <= bus_txn.offs;
                    s_sample_time     <= bus_txn.t;
                    gap_left           = pick_gap(idle_mode);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness: one long hold-off while transactions are still
    // pending, otherwise random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AT &&
                     stim_q.size() >= HOLD_PENDING) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                stall_left = pick_gap(idle_mode);
            end
        end
    end

    // Result monitor: compare each accepted elevation with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (elev_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("%0t: elevation %0d returned with none outstanding",
                             $realtime, m_elevation);
                end
            end else begin
                want_elev = elev_q.pop_front();
                if (m_elevation !== want_elev) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("%0t: elevation mismatch: expected %0d, got %0d",
                                 $realtime, want_elev, m_elevation);
                    end
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        int turn_len;
        for (int k = 0; k <= QSIZE; k++) begin
            sine_quarter[k] = taylor_sine_q15(k);
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // No active components: elevation is zero
        set_count(0);
        queue_sample(32'h0000_0000);
        queue_sample(32'hFFFF_FFFF);
        wait_idle();

        // Peak, tiny, swept and alternating components
        queue_load(0, 32'h0000_0000, 16'hFFFF, 32'h4000_0000);
        queue_load(1, 32'hFFFF_FFFF, 16'h0001, 32'hFFFF_FFFF);
        queue_load(2, 32'h0010_0000, 16'h8000, 32'h0000_0000);
        queue_load(3, 32'h8000_0000, 16'hFFFF, 32'hC000_0000);
        wait_idle();
        set_count(4);
        queue_sample(32'h0000_0000);
        queue_sample(32'h0000_0001);
        queue_sample(32'h0000_03FF);
        queue_sample(32'h0000_0400);
        queue_sample(32'h0000_0800);
        queue_sample(32'h0000_0C00);
        queue_sample(32'hFFFF_FFFF);
        queue_load(2, 32'h0000_0000, 16'h0000, 32'h0000_0000);
        queue_sample(32'h0000_0C00);
        wait_idle();
        set_count(1);
        queue_sample(32'h1234_5678);
        wait_idle();

        // Fill the whole table at full amplitude: largest sums of both signs,
        // then counts above the table size
        for (int i = 0; i < COMPONENTS; i++) begin
            queue_load(i, 32'h8000_0000, 16'hFFFF, 32'h4000_0000);
        end
        wait_idle();
        set_count(COMPONENTS);
        queue_sample(32'h0000_0000);
        queue_sample(32'h0000_0001);
        wait_idle();
        set_count(127);
        queue_sample(32'h0000_0002);
        queue_sample(32'h0000_0003);
        wait_idle();
        set_count(COMPONENTS + 1);
        queue_sample(32'hFFFF_FFFF);
        wait_idle();

        // Random phases: every entry is written now, so any count is legal
        while (n_issued < ITEM_TARGET) begin
            idle_mode = ($urandom_range(0, 2) == 0) ? 0 : 1;
            case ($urandom_range(0, 9))
                0:       set_count(0);
                1:       set_count(COMPONENTS);
                2:       set_count($urandom_range(COMPONENTS + 1, 127));
                3, 4:    set_count($urandom_range(1, 4));
                default: set_count($urandom_range(1, COMPONENTS - 1));
            endcase
            turn_len = $urandom_range(15, 60);
            repeat (turn_len) enqueue_txn(random_txn());
            wait_idle();
        end

        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("FAIL");
        $finish;
    end

endmodule

### sim.f
hdl/sss_pkg.sv
hdl/sss_ram.sv
hdl/sss_ctrl.sv
hdl/sss_datapath.sv
hdl/sinusoid_sum_synthesizer_unit.sv
dv/testbench.sv
